### hw/rtl/first_fit_lifetime_arena_allocator_macros.svh
// Assertion macro used by the port-level checker of the arena allocator.
`ifndef FIRST_FIT_LIFETIME_ARENA_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_LIFETIME_ARENA_ALLOCATOR_MACROS_SVH

// Concurrent assertion clocked by clk_i and disabled while rst_ni is low.
`define FFLA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`endif

### hw/rtl/ffla_pkg.sv
// Shared types and codes of the first-fit arena allocator.
`timescale 1ns / 1ps
package ffla_pkg;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  typedef enum logic [1:0] {
    KIND_ALLOC,
    KIND_FULL,
    KIND_STEP
  } kind_e;

  typedef struct packed {
    logic  latch;
    logic  clr_idx;
    logic  inc_idx;
    logic  set_slot;
    logic  jump;
    logic  free_slot;
    logic  load_out;
    kind_e kind;
  } ffla_cmd_t;

  typedef struct packed {
    logic mode;
    logic cur_live;
    logic idx_last;
    logic overlap;
    logic expired;
    logic out_free;
  } ffla_sts_t;

endpackage

### hw/rtl/ffla_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module ffla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

### hw/rtl/ffla_ctrl.sv
// Sequencer for the free-slot search, first-fit scan and release sweep.
`timescale 1ns / 1ps
module ffla_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ffla_pkg::ffla_sts_t sts_i,
  output ffla_pkg::ffla_cmd_t cmd_o
);
  import ffla_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_FREE    = 3'd1;
  localparam logic [2:0] S_FIT_RD  = 3'd2;
  localparam logic [2:0] S_FIT_CHK = 3'd3;
  localparam logic [2:0] S_REL_RD  = 3'd4;
  localparam logic [2:0] S_REL_CHK = 3'd5;
  localparam logic [2:0] S_FIN     = 3'd6;

  logic [2:0] state_q, state_d;
  kind_e      kind_q, kind_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    cmd_o      = '0;
    cmd_o.kind = kind_q;
    state_d    = state_q;
    kind_d     = kind_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch   = 1'b1;
          cmd_o.clr_idx = 1'b1;
          state_d       = sts_i.mode ? S_REL_RD : S_FREE;
        end
      end
      S_FREE: begin
        if (!sts_i.cur_live) begin
          cmd_o.set_slot = 1'b1;
          cmd_o.clr_idx  = 1'b1;
          state_d        = S_FIT_RD;
        end else if (sts_i.idx_last) begin
          kind_d  = KIND_FULL;
          state_d = S_FIN;
        end else begin
          cmd_o.inc_idx = 1'b1;
        end
      end
      S_FIT_RD: state_d = S_FIT_CHK;
      S_FIT_CHK: begin
        // An overlap moves the candidate past the block and restarts the scan.
        if (sts_i.cur_live && sts_i.overlap) begin
          cmd_o.jump = 1'b1;
          state_d    = S_FIT_RD;
        end else if (sts_i.idx_last) begin
          kind_d  = KIND_ALLOC;
          state_d = S_FIN;
        end else begin
          cmd_o.inc_idx = 1'b1;
          state_d       = S_FIT_RD;
        end
      end
      S_REL_RD: state_d = S_REL_CHK;
      S_REL_CHK: begin
        cmd_o.free_slot = sts_i.cur_live && sts_i.expired;
        if (sts_i.idx_last) begin
          kind_d  = KIND_STEP;
          state_d = S_FIN;
        end else begin
          cmd_o.inc_idx = 1'b1;
          state_d       = S_REL_RD;
        end
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      kind_q  <= KIND_ALLOC;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
    end
  end

endmodule

### hw/rtl/ffla_dp.sv
// Slot table, candidate arithmetic and result register of the allocator.
`timescale 1ns / 1ps
module ffla_dp #(
  parameter int SLOTS     = 64,
  parameter int ADDR_BITS = 32,
  parameter int STEP_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ffla_pkg::ffla_cmd_t cmd_i,
  output ffla_pkg::ffla_sts_t sts_o,
  input  logic                mode_i,
  input  logic [31:0]         block_size_i,
  input  logic [15:0]         expiry_step_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [31:0]         start_address_o,
  output logic [31:0]         end_address_o,
  output logic [5:0]          slot_used_o,
  output logic [31:0]         high_water_o,
  output logic [6:0]          freed_count_o,
  output logic [1:0]          status_o
);
  import ffla_pkg::*;

  localparam int IW = $clog2(SLOTS);
  localparam int FW = $clog2(SLOTS + 1);
  localparam int SW = ((ADDR_BITS > 32) ? ADDR_BITS : 32) + 1;
  localparam int DW = 2 * ADDR_BITS + STEP_BITS;

  logic [IW-1:0]        idx_q, slot_q;
  logic [ADDR_BITS-1:0] cand_q, peak_q;
  logic [31:0]          size_q;
  logic [STEP_BITS-1:0] exp_q, step_q;
  logic [SLOTS-1:0]     live_q;
  logic [FW-1:0]        freed_q;
  logic                 out_valid_q;

  logic [DW-1:0]        rd_data;
  logic [ADDR_BITS-1:0] rd_beg, rd_end;
  logic [STEP_BITS-1:0] rd_exp;
  logic [31:0]          exp_ext;
  logic [SW-1:0]        cand_ext, size_ext, beg_ext, end_sum, peak_ext;
  logic [31:0]          slot_ext, freed_ext;
  logic                 ovf, commit, step_adv;

  assign exp_ext  = {16'd0, expiry_step_i};
  assign {rd_beg, rd_end, rd_exp} = rd_data;
  assign cand_ext = {{(SW-ADDR_BITS){1'b0}}, cand_q};
  assign size_ext = {{(SW-32){1'b0}}, size_q};
  assign beg_ext  = {{(SW-ADDR_BITS){1'b0}}, rd_beg};
  assign peak_ext = {{(SW-ADDR_BITS){1'b0}}, peak_q};
  assign end_sum  = cand_ext + size_ext;
  assign ovf      = |end_sum[SW-1:ADDR_BITS];
  assign slot_ext  = {{(32-IW){1'b0}}, slot_q};
  assign freed_ext = {{(32-FW){1'b0}}, freed_q};

  assign commit   = cmd_i.load_out && (cmd_i.kind == KIND_ALLOC) && !ovf;
  assign step_adv = cmd_i.load_out && (cmd_i.kind == KIND_STEP);

  assign sts_o.mode     = mode_i;
  assign sts_o.cur_live = live_q[idx_q];
  assign sts_o.idx_last = (idx_q == IW'(SLOTS - 1));
  assign sts_o.overlap  = (end_sum > beg_ext) && (cand_q < rd_end);
  assign sts_o.expired  = (rd_exp <= step_q);
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  ffla_ram #(
    .WIDTH(DW),
    .DEPTH(SLOTS)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (commit),
    .waddr_i(slot_q),
    .wdata_i({cand_q, end_sum[ADDR_BITS-1:0], exp_q}),
    .raddr_i(idx_q),
    .rdata_o(rd_data)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      size_q  <= block_size_i;
      exp_q   <= exp_ext[STEP_BITS-1:0];
      cand_q  <= '0;
      freed_q <= '0;
    end else begin
      if (cmd_i.jump) begin
        cand_q <= rd_end;
      end
      if (cmd_i.free_slot) begin
        freed_q <= freed_q + 1'b1;
      end
    end
    if (cmd_i.set_slot) begin
      slot_q <= idx_q;
    end
    if (cmd_i.clr_idx || cmd_i.jump) begin
      idx_q <= '0;
    end else if (cmd_i.inc_idx) begin
      idx_q <= idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q          <= '0;
      step_q          <= '0;
      peak_q          <= '0;
      out_valid_q     <= 1'b0;
      start_address_o <= '0;
      end_address_o   <= '0;
      slot_used_o     <= '0;
      high_water_o    <= '0;
      freed_count_o   <= '0;
      status_o        <= ST_OK;
    end else begin
      if (cmd_i.free_slot) begin
        live_q[idx_q] <= 1'b0;
      end
      if (commit) begin
        live_q[slot_q] <= 1'b1;
        if (end_sum > peak_ext) begin
          peak_q <= end_sum[ADDR_BITS-1:0];
        end
      end
      if (step_adv) begin
        step_q <= step_q + 1'b1;
      end
      if (cmd_i.load_out) begin
        out_valid_q     <= 1'b1;
        start_address_o <= '0;
        end_address_o   <= '0;
        slot_used_o     <= '0;
        freed_count_o   <= '0;
        high_water_o    <= peak_ext[31:0];
        status_o        <= ST_OK;
        unique case (cmd_i.kind)
          KIND_ALLOC: begin
            if (ovf) begin
              status_o <= ST_OVF;
            end else begin
              start_address_o <= cand_ext[31:0];
              end_address_o   <= end_sum[31:0];
              slot_used_o     <= slot_ext[5:0];
              if (end_sum > peak_ext) begin
                high_water_o <= end_sum[31:0];
              end
            end
          end
          KIND_FULL: status_o <= ST_FULL;
          KIND_STEP: freed_count_o <= freed_ext[6:0];
          default:   status_o <= ST_OK;
        endcase
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### hw/rtl/first_fit_lifetime_arena_allocator.sv
// Allocate: a search for the lowest free slot, then a first-fit scan over all slots;
// each overlap jump restarts the scan.
// End of step: a sweep of all slots; a full table answers after the slot search.
// One item is in work at a time; the next is taken in the cycle after the result is loaded,
// even while that result still waits in the output register.
// Reset clears all live bits, the step count and the high-water mark at once.
`timescale 1ns / 1ps
module first_fit_lifetime_arena_allocator #(
  parameter int SLOTS     = 64,
  parameter int ADDR_BITS = 32,
  parameter int STEP_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        mode_i,
  input  logic [31:0] block_size_i,
  input  logic [15:0] expiry_step_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] start_address_o,
  output logic [31:0] end_address_o,
  output logic [5:0]  slot_used_o,
  output logic [31:0] high_water_o,
  output logic [6:0]  freed_count_o,
  output logic [1:0]  status_o
);
  import ffla_pkg::*;

  ffla_cmd_t cmd;
  ffla_sts_t sts;

  ffla_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  ffla_dp #(
    .SLOTS    (SLOTS),
    .ADDR_BITS(ADDR_BITS),
    .STEP_BITS(STEP_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .mode_i         (mode_i),
    .block_size_i   (block_size_i),
    .expiry_step_i  (expiry_step_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .start_address_o(start_address_o),
    .end_address_o  (end_address_o),
    .slot_used_o    (slot_used_o),
    .high_water_o   (high_water_o),
    .freed_count_o  (freed_count_o),
    .status_o       (status_o)
  );

endmodule

### hw/rtl/ffla_checker.sv
// Port-level checks of the arena allocator and their bind to the top level.
`timescale 1ns / 1ps
`include "first_fit_lifetime_arena_allocator_macros.svh"
module ffla_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] start_address_o,
  input logic [31:0] end_address_o,
  input logic [5:0]  slot_used_o,
  input logic [31:0] high_water_o,
  input logic [6:0]  freed_count_o,
  input logic [1:0]  status_o
);
  import ffla_pkg::*;

  `FFLA_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(start_address_o) && $stable(status_o), "stalled word changed")
  `FFLA_ASSERT(a_hw_mono, high_water_o >= $past(high_water_o), "high-water mark decreased")
  `FFLA_ASSERT(a_err_zero, out_valid_o && status_o != ST_OK |-> start_address_o == 0 && end_address_o == 0 && slot_used_o == 0 && freed_count_o == 0, "error word carries data")
  `FFLA_ASSERT(a_step_word, out_valid_o && freed_count_o != 0 |-> status_o == ST_OK && start_address_o == 0 && end_address_o == 0, "release word malformed")

endmodule

bind first_fit_lifetime_arena_allocator ffla_checker u_ffla_checker (.*);

### bench/testbench.sv
// Self-checking testbench for the first-fit lifetime arena allocator.
`timescale 1ns / 1ps
module testbench;
  import ffla_pkg::*;

  localparam int SLOTS = 64;
  localparam int RANDOM_ITEMS = 1000;
  localparam longint CYCLE_LIMIT = 40_000_000;
  localparam bit MODE_ALLOC = 1'b0;
  localparam bit MODE_STEP  = 1'b1;

  typedef struct packed {
    logic [31:0] base_off;
    logic [31:0] end_addr;
    logic [5:0]  slot;
    logic [31:0] peak;
    logic [6:0]  freed;
    logic [1:0]  status;
  } arena_word_t;

  typedef struct packed {
    logic        mode;
    logic [31:0] size;
    logic [15:0] expiry;
    logic        typed;
    arena_word_t want;
  } directed_row_t;

  localparam int DIRECTED_ROWS = 12;
  localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{MODE_STEP,  32'd0,          16'd0,      1'b1, '{32'd0, 32'd0, 6'd0, 32'd0, 7'd0, ST_OK}},
    '{MODE_ALLOC, 32'd0,          16'd5,      1'b1, '{32'd0, 32'd0, 6'd0, 32'd0, 7'd0, ST_OK}},
    '{MODE_ALLOC, 32'd16,         16'hFFFF,   1'b1,
      '{32'd0, 32'd16, 6'd1, 32'd16, 7'd0, ST_OK}},
    '{MODE_ALLOC, 32'd8,          16'd1,      1'b1,
      '{32'd16, 32'd24, 6'd2, 32'd24, 7'd0, ST_OK}},
    '{MODE_ALLOC, 32'hFFFF_FFFF,  16'd0,      1'b1, '{32'd0, 32'd0, 6'd0, 32'd24, 7'd0, ST_OVF}},
    '{MODE_ALLOC, 32'hFFFF_FFE7,  16'd2,      1'b1,
      '{32'd24, 32'hFFFF_FFFF, 6'd3, 32'hFFFF_FFFF, 7'd0, ST_OK}},
    '{MODE_STEP,  32'd0,          16'd0,      1'b1,
      '{32'd0, 32'd0, 6'd0, 32'hFFFF_FFFF, 7'd1, ST_OK}},
    '{MODE_ALLOC, 32'd4,          16'd3,      1'b0, '0},
    '{MODE_STEP,  32'hA5A5_5A5A,  16'h5A5A,   1'b0, '0},
    '{MODE_ALLOC, 32'd0,          16'd4,      1'b0, '0},
    '{MODE_STEP,  32'd0,          16'd0,      1'b0, '0},
    '{MODE_STEP,  32'd0,          16'd0,      1'b0, '0}
  };

  logic        clk_i, rst_ni;
  logic        in_valid_i, in_stall_o, mode_i;
  logic [31:0] block_size_i;
  logic [15:0] expiry_step_i;
  logic        out_valid_o, out_stall_i;
  logic [31:0] start_address_o, end_address_o, high_water_o;
  logic [5:0]  slot_used_o;
  logic [6:0]  freed_count_o;
  logic [1:0]  status_o;

  first_fit_lifetime_arena_allocator dut (.*);

  // Shadow of the arena table.
  bit          live_q [SLOTS];
  logic [31:0] begin_q [SLOTS];
  logic [31:0] end_q [SLOTS];
  logic [15:0] expiry_q [SLOTS];
  logic [15:0] step_q;
  logic [31:0] peak_q;

  arena_word_t pending_words[$];
  int mismatches, checked, full_seen, ovf_seen, freed_total;
  longint cycles = 0;
  bit long_hold_req;

  function automatic arena_word_t place_or_release(bit mode, logic [31:0] size,
                                                   logic [15:0] expiry);
    arena_word_t w;
    int slot, i, freed;
    logic [32:0] cand, fin;
    w = '0;
    slot = -1;
    freed = 0;
    if (mode == MODE_STEP) begin
      for (i = 0; i < SLOTS; i++) begin
        if (live_q[i] && expiry_q[i] <= step_q) begin
          live_q[i] = 0;
          freed++;
        end
      end
      step_q = step_q + 16'd1;
      w.freed = freed[6:0];
      w.peak = peak_q;
      w.status = ST_OK;
      return w;
    end
    for (i = SLOTS - 1; i >= 0; i--) if (!live_q[i]) slot = i;
    w.peak = peak_q;
    if (slot < 0) begin
      w.status = ST_FULL;
      return w;
    end
    cand = '0;
    i = 0;
    // Each conflict moves the candidate past the block and restarts the scan.
    while (i < SLOTS) begin
      if (live_q[i] && cand + size > {1'b0, begin_q[i]} && cand < {1'b0, end_q[i]}) begin
        cand = {1'b0, end_q[i]};
        i = 0;
      end else begin
        i++;
      end
    end
    fin = cand + size;
    if (fin > 33'hFFFF_FFFF) begin
      w.status = ST_OVF;
      return w;
    end
    live_q[slot] = 1;
    begin_q[slot] = cand[31:0];
    end_q[slot] = fin[31:0];
    expiry_q[slot] = expiry;
    if (fin[31:0] > peak_q) peak_q = fin[31:0];
    w.base_off = cand[31:0];
    w.end_addr = fin[31:0];
    w.slot = slot[5:0];
    w.peak = peak_q;
    w.status = ST_OK;
    return w;
  endfunction

  initial begin
    clk_i = 0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycles,
               pending_words.size());
      $display("testbench failed");
      $finish;
    end
  end

  // Offers one word and waits for it to be taken.
  task automatic offer_word(bit mode, logic [31:0] size, logic [15:0] expiry,
                            bit typed, arena_word_t want);
    arena_word_t w;
    in_valid_i <= 1'b1;
    mode_i <= mode;
    block_size_i <= size;
    expiry_step_i <= expiry;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    w = place_or_release(mode, size, expiry);
    pending_words.push_back(typed ? want : w);
  endtask

  task automatic sender_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return;
    in_valid_i <= 1'b0;
    if (r < 95) repeat ($urandom_range(1, 4)) @(posedge clk_i);
    else repeat ($urandom_range(20, 200)) @(posedge clk_i);
  endtask

  // Receiver: random stalls in phases, one long hold-off while items keep coming.
  initial begin
    int phase_left, busy_level, hold;
    phase_left = 0;
    busy_level = 0;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        arena_word_t got;
        arena_word_t exp_w;
        got = '{start_address_o, end_address_o, slot_used_o, high_water_o,
                freed_count_o, status_o};
        checked++;
        if (pending_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word %h", got);
        end else begin
          exp_w = pending_words.pop_front();
          if (got !== exp_w) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("word %0d exp: start %h end %h slot %0d hw %h freed %0d st %0d",
                       checked, exp_w.base_off, exp_w.end_addr, exp_w.slot, exp_w.peak,
                       exp_w.freed, exp_w.status);
              $display("word %0d got: start %h end %h slot %0d hw %h freed %0d st %0d",
                       checked, got.base_off, got.end_addr, got.slot, got.peak,
                       got.freed, got.status);
            end
          end
        end
      end
      if (long_hold_req) begin
        long_hold_req = 0;
        out_stall_i <= 1'b1;
        for (hold = 0; hold < 3000; hold++) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        if (phase_left == 0) begin
          phase_left = $urandom_range(50, 400);
          busy_level = $urandom_range(0, 3);
        end
        phase_left--;
        case (busy_level)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 9) < 2);
          2: out_stall_i <= ($urandom_range(0, 9) < 6);
          default: begin
            // Rare stalls that then last for a while.
            if (out_stall_i) out_stall_i <= ($urandom_range(0, 30) != 0);
            else out_stall_i <= ($urandom_range(0, 299) == 0);
          end
        endcase
      end
    end
  end

  initial begin
    int n, r, burst_left, drain;
    logic [31:0] size;
    logic [15:0] expiry;
    bit mode;
    mismatches = 0;
    checked = 0;
    full_seen = 0;
    ovf_seen = 0;
    freed_total = 0;
    long_hold_req = 0;
    burst_left = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    mode_i = MODE_ALLOC;
    block_size_i = '0;
    expiry_step_i = '0;
    for (n = 0; n < SLOTS; n++) live_q[n] = 0;
    step_q = '0;
    peak_q = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (n = 0; n < DIRECTED_ROWS; n++) begin
      offer_word(DIRECTED[n].mode, DIRECTED[n].size, DIRECTED[n].expiry,
                 DIRECTED[n].typed, DIRECTED[n].want);
      sender_gap();
    end

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 150) long_hold_req = 1;
      if (n == 500) begin
        in_valid_i <= 1'b0;
        while (pending_words.size() != 0) @(posedge clk_i);
      end
      if (burst_left == 0 && $urandom_range(0, 99) == 0) burst_left = 70;
      r = $urandom_range(0, 99);
      mode = MODE_ALLOC;
      size = $urandom_range(1, 4096);
      expiry = step_q + 16'($urandom_range(0, 6));
      if (burst_left > 0) begin
        // Long-lived small blocks pile up until the table runs out of slots.
        burst_left--;
        size = $urandom_range(0, 64);
        expiry = step_q + 16'($urandom_range(20, 200));
      end else if (r < 25) begin
        mode = MODE_STEP;
        size = $urandom;
        expiry = $urandom;
      end else if (r < 30) begin
        size = $urandom;
      end else if (r < 33) begin
        size = '0;
      end else if (r < 36) begin
        expiry = $urandom;
      end
      offer_word(mode, size, expiry, 1'b0, '0);
      if (pending_words[$].status == ST_FULL) full_seen++;
      if (pending_words[$].status == ST_OVF) ovf_seen++;
      freed_total += pending_words[$].freed;
      sender_gap();
    end
    in_valid_i <= 1'b0;

    while (pending_words.size() != 0) @(posedge clk_i);
    for (drain = 0; drain < 300; drain++) @(posedge clk_i);

    $display("%0d words checked: %0d full-table and %0d overflow answers, %0d blocks freed",
             checked, full_seen, ovf_seen, freed_total);
    $display("final step %0d, high-water mark %h", step_q, peak_q);
    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("testbench failed");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/ffla_pkg.sv
hw/rtl/ffla_ram.sv
hw/rtl/ffla_ctrl.sv
hw/rtl/ffla_dp.sv
hw/rtl/first_fit_lifetime_arena_allocator.sv
hw/rtl/ffla_checker.sv
bench/testbench.sv
